[sv/top_k_hit_selector_defines.svh]
// ---------------------------------------------------------------------------
// top_k_hit_selector_defines: assertion macros for the hit selector checks
// ---------------------------------------------------------------------------
`ifndef TOP_K_HIT_SELECTOR_DEFINES_SVH
`define TOP_K_HIT_SELECTOR_DEFINES_SVH

// same-cycle implication, sampled on i_clk, disabled in reset
`define TKHS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on i_clk, disabled in reset
`define TKHS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/tkhs_pkg.sv]
// ---------------------------------------------------------------------------
// tkhs_pkg: shared types and constants of the top-k hit selector
// Word layouts, entry type, ranking function and scan control.
// ---------------------------------------------------------------------------
package tkhs_pkg;

    localparam int MAX_KEEP_DEF = 32;
    localparam logic [5:0] KEEP_LIMIT_RST = 6'd20;

    localparam logic CMD_OFFER = 1'b0;
    localparam logic CMD_DRAIN = 1'b1;

    typedef struct packed {
        logic        cmd;
        logic [31:0] hit_score;
        logic [1:0]  hit_kind;
        logic [31:0] hit_ordinal;
    } t_hit_in;

    typedef struct packed {
        logic        out_valid;
        logic [31:0] out_score;
        logic [1:0]  out_kind;
        logic [31:0] out_ordinal;
        logic [31:0] prune_threshold;
        logic [5:0]  kept_count;
        logic        last_item;
    } t_result;

    typedef struct packed {
        logic [31:0] score;
        logic [1:0]  kind;
        logic [31:0] ordinal;
    } t_entry;

    typedef enum logic {
        SCAN_WORST = 1'b0,
        SCAN_BEST  = 1'b1
    } t_scan_mode;

    typedef struct packed {
        logic       start;
        logic       vld;
        logic       skip;
        t_scan_mode mode;
    } t_scan_ctl;

    // true if a ranks strictly ahead of b: higher score, lower kind, lower ordinal
    function automatic logic rank_better(t_entry a, t_entry b);
        logic res;
        if (a.score != b.score) begin
            res = (a.score > b.score);
        end else if (a.kind != b.kind) begin
            res = (a.kind < b.kind);
        end else begin
            res = (a.ordinal < b.ordinal);
        end
        return res;
    endfunction

endpackage

[sv/tkhs_ram.sv]
// ---------------------------------------------------------------------------
// tkhs_ram: entry store of the hit selector
// One write port, one read port with registered read data.
// ---------------------------------------------------------------------------
module tkhs_ram #(
    parameter int MAX_KEEP = tkhs_pkg::MAX_KEEP_DEF,
    localparam int IW      = (MAX_KEEP > 1) ? $clog2(MAX_KEEP) : 1
) (
    input  logic                    i_clk,
    input  logic                    i_wr_en,
    input  logic [IW-1:0]           i_wr_addr,
    input  tkhs_pkg::t_entry        i_wr_data,
    input  logic                    i_rd_en,
    input  logic [IW-1:0]           i_rd_addr,
    output tkhs_pkg::t_entry        o_rd_data
);
    tkhs_pkg::t_entry r_mem [MAX_KEEP];
    tkhs_pkg::t_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[sv/tkhs_scan.sv]
// ---------------------------------------------------------------------------
// tkhs_scan: shared rank compare unit
// Track the worst or best entry of a stream, plus the two lowest scores.
// ---------------------------------------------------------------------------
module tkhs_scan #(
    parameter int MAX_KEEP = tkhs_pkg::MAX_KEEP_DEF,
    localparam int IW      = (MAX_KEEP > 1) ? $clog2(MAX_KEEP) : 1
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  tkhs_pkg::t_scan_ctl i_ctl,
    input  tkhs_pkg::t_entry    i_entry,
    input  logic [IW-1:0]       i_idx,
    output tkhs_pkg::t_entry    o_pick,
    output logic [IW-1:0]       o_pick_idx,
    output logic [31:0]         o_min2
);
    logic             r_found;
    tkhs_pkg::t_entry r_pick;
    logic [IW-1:0]    r_pick_idx;
    logic [31:0]      r_m1;
    logic [31:0]      r_m2;

    logic take;
    logic ahead;
    logic load;

    always_comb begin
        take = i_ctl.vld && !i_ctl.skip;
        if (i_ctl.mode == tkhs_pkg::SCAN_WORST) begin
            ahead = tkhs_pkg::rank_better(r_pick, i_entry);
        end else begin
            ahead = tkhs_pkg::rank_better(i_entry, r_pick);
        end
        load = take && (!r_found || ahead);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
        end else if (i_ctl.start) begin
            r_found <= 1'b0;
        end else if (take) begin
            r_found <= 1'b1;
        end
    end

    // pick and running lowest scores
    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_m1 <= '1;
            r_m2 <= '1;
        end else if (take) begin
            if (i_entry.score < r_m1) begin
                r_m2 <= r_m1;
                r_m1 <= i_entry.score;
            end else if (i_entry.score < r_m2) begin
                r_m2 <= i_entry.score;
            end
        end
        if (load) begin
            r_pick     <= i_entry;
            r_pick_idx <= i_idx;
        end
    end

    assign o_pick     = r_pick;
    assign o_pick_idx = r_pick_idx;
    assign o_min2     = r_m2;

endmodule

[sv/top_k_hit_selector.sv]
// ---------------------------------------------------------------------------
// top_k_hit_selector: keeps the best scored hits of a search
// Offer appends or replaces the worst hit; drain emits hits in rank order.
// ---------------------------------------------------------------------------
// Usage:
//  - Input words (i_in_valid / o_in_stall) carry a command and one hit. An
//    offer gives exactly one output word with the pruning threshold and
//    the count; a drain gives one word per held hit, best first, with
//    last_item on the final one (one empty word if nothing is held).
//  - keep_limit is written on the cfg channel (always ready) while idle.
//  - One word is processed at a time; o_in_stall is high until it is done.
//  - Offer below the limit appends. Offer when full: one pass of the shared
//    compare unit over the held entries through the single RAM read port.
//  - Drain of n hits: n passes of the same unit.
//  - Output words sit in one register; a stall on i_out_stall holds the
//    word and pauses the sequencer at its next emit, nothing is dropped.
//  - Reset empties the buffer and sets keep_limit to 20; the entry RAM is
//    not cleared since entries above the count are never read.
// ---------------------------------------------------------------------------
module top_k_hit_selector #(
    parameter int MAX_KEEP = tkhs_pkg::MAX_KEEP_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  tkhs_pkg::t_hit_in i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output tkhs_pkg::t_result o_out_data,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [5:0]        i_cfg_data
);
    localparam int IW = (MAX_KEEP > 1) ? $clog2(MAX_KEEP) : 1;
    localparam int CW = $clog2(MAX_KEEP + 1);

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_APPEND = 6'b000010,
        ST_SCAN   = 6'b000100,
        ST_REPL   = 6'b001000,
        ST_EMIT   = 6'b010000,
        ST_DEMIT  = 6'b100000
    } t_state;

    t_state            r_state, n_state;
    logic [5:0]        r_keep;
    logic [CW-1:0]     r_held, n_held;
    logic [31:0]       r_min, n_min;
    tkhs_pkg::t_hit_in r_hit;
    logic [CW-1:0]     r_issue, n_issue;
    logic              r_tag_vld;
    logic [IW-1:0]     r_tag_idx;
    logic [MAX_KEEP-1:0] r_taken, n_taken;
    logic [CW-1:0]     r_pass, n_pass;
    tkhs_pkg::t_result r_out, n_out;
    logic              r_out_vld;

    logic                lim_over;
    logic [CW-1:0]       eff_lim;
    logic                accept;
    logic                slot_free;
    logic                out_load;
    logic                rd_en;
    logic                scan_done;
    logic                wr_en;
    logic [IW-1:0]       wr_addr;
    tkhs_pkg::t_entry    wr_data;
    tkhs_pkg::t_entry    new_hit;
    tkhs_pkg::t_entry    rd_data;
    tkhs_pkg::t_entry    pick;
    logic [IW-1:0]       pick_idx;
    logic [31:0]         min2;
    tkhs_pkg::t_scan_ctl scan_ctl;

    // clamp the limit: zero acts as one, above depth acts as the depth
    always_comb begin
        lim_over = ({1'b0, r_keep} > 7'(MAX_KEEP));
        if (r_keep == 6'd0) begin
            eff_lim = CW'(1);
        end else if (lim_over) begin
            eff_lim = CW'(MAX_KEEP);
        end else begin
            eff_lim = CW'(r_keep);
        end
    end

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != ST_IDLE);
    assign accept      = i_in_valid && (r_state == ST_IDLE);
    assign slot_free   = !r_out_vld || !i_out_stall;

    assign new_hit = '{score: r_hit.hit_score, kind: r_hit.hit_kind,
                       ordinal: r_hit.hit_ordinal};

    // scan read stream: one RAM read per cycle, tagged in the cycle after
    assign rd_en     = (r_state == ST_SCAN) && (r_issue != r_held);
    assign scan_done = (r_state == ST_SCAN) && (r_issue == r_held) && !r_tag_vld;

    always_comb begin
        n_state  = r_state;
        n_held   = r_held;
        n_min    = r_min;
        n_issue  = r_issue;
        n_taken  = r_taken;
        n_pass   = r_pass;
        n_out    = r_out;
        out_load = 1'b0;
        wr_en    = 1'b0;
        wr_addr  = r_held[IW-1:0];
        wr_data  = new_hit;

        scan_ctl.start = 1'b0;
        scan_ctl.vld   = r_tag_vld;
        scan_ctl.skip  = (r_hit.cmd == tkhs_pkg::CMD_DRAIN) && r_taken[r_tag_idx];
        scan_ctl.mode  = (r_hit.cmd == tkhs_pkg::CMD_DRAIN) ? tkhs_pkg::SCAN_BEST
                                                           : tkhs_pkg::SCAN_WORST;
        if (rd_en) begin
            n_issue = r_issue + CW'(1);
        end

        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (i_in_data.cmd == tkhs_pkg::CMD_OFFER) begin
                        if (r_held < eff_lim) begin
                            n_state = ST_APPEND;
                        end else begin
                            scan_ctl.start = 1'b1;
                            n_issue        = '0;
                            n_state        = ST_SCAN;
                        end
                    end else if (r_held == '0) begin
                        n_state = ST_EMIT;
                    end else begin
                        scan_ctl.start = 1'b1;
                        n_issue        = '0;
                        n_taken        = '0;
                        n_pass         = '0;
                        n_state        = ST_SCAN;
                    end
                end
            end
            ST_APPEND: begin
                wr_en   = 1'b1;
                n_held  = r_held + CW'(1);
                n_min   = ((r_held == '0) || (new_hit.score < r_min)) ? new_hit.score : r_min;
                n_state = ST_EMIT;
            end
            ST_SCAN: begin
                if (scan_done) begin
                    n_state = (r_hit.cmd == tkhs_pkg::CMD_DRAIN) ? ST_DEMIT : ST_REPL;
                end
            end
            ST_REPL: begin
                // worst entry holds the lowest score; without it the next is min2
                if (tkhs_pkg::rank_better(new_hit, pick)) begin
                    wr_en   = 1'b1;
                    wr_addr = pick_idx;
                    n_min   = (new_hit.score < min2) ? new_hit.score : min2;
                end
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (slot_free) begin
                    out_load              = 1'b1;
                    n_out                 = '0;
                    n_out.last_item       = 1'b1;
                    if (r_hit.cmd == tkhs_pkg::CMD_OFFER) begin
                        n_out.kept_count      = 6'(r_held);
                        n_out.prune_threshold = (r_held >= eff_lim) ? r_min : 32'd0;
                    end
                    n_state = ST_IDLE;
                end
            end
            ST_DEMIT: begin
                if (slot_free) begin
                    out_load          = 1'b1;
                    n_out             = '0;
                    n_out.out_valid   = 1'b1;
                    n_out.out_score   = pick.score;
                    n_out.out_kind    = pick.kind;
                    n_out.out_ordinal = pick.ordinal;
                    n_out.last_item   = (r_pass == (r_held - CW'(1)));
                    n_taken[pick_idx] = 1'b1;
                    if (r_pass == (r_held - CW'(1))) begin
                        n_held  = '0;
                        n_state = ST_IDLE;
                    end else begin
                        scan_ctl.start = 1'b1;
                        n_issue        = '0;
                        n_pass         = r_pass + CW'(1);
                        n_state        = ST_SCAN;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_held    <= '0;
            r_keep    <= tkhs_pkg::KEEP_LIMIT_RST;
            r_out_vld <= 1'b0;
            r_tag_vld <= 1'b0;
            r_issue   <= '0;
            r_pass    <= '0;
            r_taken   <= '0;
        end else begin
            r_state   <= n_state;
            r_held    <= n_held;
            r_tag_vld <= rd_en;
            r_issue   <= n_issue;
            r_pass    <= n_pass;
            r_taken   <= n_taken;
            if (i_cfg_valid) begin
                r_keep <= i_cfg_data;
            end
            // hold the word while stalled, drop it once taken
            if (out_load) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_min     <= n_min;
        r_out     <= n_out;
        r_tag_idx <= r_issue[IW-1:0];
        if (accept) begin
            r_hit <= i_in_data;
        end
    end

    tkhs_ram #(
        .MAX_KEEP (MAX_KEEP)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_issue[IW-1:0]),
        .o_rd_data (rd_data)
    );

    tkhs_scan #(
        .MAX_KEEP (MAX_KEEP)
    ) u_scan (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (scan_ctl),
        .i_entry    (rd_data),
        .i_idx      (r_tag_idx),
        .o_pick     (pick),
        .o_pick_idx (pick_idx),
        .o_min2     (min2)
    );

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

endmodule

[sv/tkhs_checker.sv]
// ---------------------------------------------------------------------------
// tkhs_checker: port-level checks of the hit selector
// Bound to the top level; watches the input and output channels.
// ---------------------------------------------------------------------------
`include "top_k_hit_selector_defines.svh"

module tkhs_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              o_in_stall,
    input logic              o_out_valid,
    input logic              i_out_stall,
    input tkhs_pkg::t_result o_out_data
);

    // hold a stalled output word
    `TKHS_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_data), "output word changed while stalled")

    // an accepted word keeps the block busy in the next cycle
    `TKHS_ASSERT_NEXT(a_busy_after_accept, i_in_valid && !o_in_stall, o_in_stall, "input taken again right after accept")

    // a word without a hit carries zero hit fields
    `TKHS_ASSERT_NOW(a_empty_hit_zero, o_out_valid && !o_out_data.out_valid, (o_out_data.out_score == 32'd0) && (o_out_data.out_kind == 2'd0) && (o_out_data.out_ordinal == 32'd0), "hit fields set on a word without a hit")

    // drained hits report an empty buffer and no threshold
    `TKHS_ASSERT_NOW(a_drain_status, o_out_valid && o_out_data.out_valid, (o_out_data.prune_threshold == 32'd0) && (o_out_data.kept_count == 6'd0), "status fields set on a drained hit")

endmodule

bind top_k_hit_selector tkhs_checker u_tkhs_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);

[sim/tb.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb: self-checking bench for the top-k hit selector
// Offer and drain words go in over a valid/stall channel with random gaps.
// A shadow list of the kept hits predicts every output word: the threshold
// and count for each offer, and the ranked hits for each drain. Each output
// word is compared, field by field, with the oldest predicted word.
// ---------------------------------------------------------------------------
module tb;

    localparam int          DEPTH       = tkhs_pkg::MAX_KEEP_DEF;
    localparam int          SETTLE      = 8;
    localparam int          END_WAIT    = 64;
    localparam int          HOLD_CYCLES = 300;
    localparam int unsigned RUN_LIMIT   = 2_000_000;

    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              i_in_valid  = 1'b0;
    logic              o_in_stall;
    tkhs_pkg::t_hit_in i_in_data   = '0;
    logic              o_out_valid;
    logic              i_out_stall = 1'b0;
    tkhs_pkg::t_result o_out_data;
    logic              i_cfg_valid = 1'b0;
    logic              o_cfg_ready;
    logic [5:0]        i_cfg_data  = '0;

    // shadow copy of the block: kept hits, their count and the keep limit
    tkhs_pkg::t_entry shadow_hits [DEPTH];
    int               shadow_count = 0;
    logic [5:0]       shadow_limit = tkhs_pkg::KEEP_LIMIT_RST;

    tkhs_pkg::t_result pending_words [$];
    int                mismatches  = 0;
    int unsigned       cycle_count = 0;
    bit                quiet       = 1'b0;

    // receiver: the long hold-off is started by a toggle from the test
    logic rx_hold_tgl  = 1'b0;
    logic rx_hold_seen = 1'b0;
    int   rx_hold_left = 0;
    int   rx_wait_left = 0;
    int   rx_draw;
    tkhs_pkg::t_result want_w;

    top_k_hit_selector u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // hard stop if the block hangs
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == RUN_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // ---------------------------------------------------------------------
    // shadow list
    // ---------------------------------------------------------------------

    function automatic int active_limit(input logic [5:0] lim);
        int v;
        v = lim;
        if (v == 0) v = 1;
        if (v > DEPTH) v = DEPTH;
        return v;
    endfunction

    // higher score wins, then lower kind, then lower ordinal
    function automatic bit ahead_of(input tkhs_pkg::t_entry a, input tkhs_pkg::t_entry b);
        return {a.score, ~a.kind, ~a.ordinal} > {b.score, ~b.kind, ~b.ordinal};
    endfunction

    // threshold only exists once the list counts as full
    function automatic logic [31:0] min_kept_score();
        logic [31:0] m;
        if (shadow_count < active_limit(shadow_limit) || shadow_count == 0) return '0;
        m = shadow_hits[0].score;
        for (int i = 1; i < shadow_count; i++)
            if (shadow_hits[i].score < m) m = shadow_hits[i].score;
        return m;
    endfunction

    // apply one accepted input word and queue the words it must produce
    task automatic apply_to_shadow_list(input tkhs_pkg::t_hit_in w);
        tkhs_pkg::t_entry  hit;
        tkhs_pkg::t_entry  tmp;
        tkhs_pkg::t_result r;
        int                worst;
        int                best;
        int                n;
        hit = '{score: w.hit_score, kind: w.hit_kind, ordinal: w.hit_ordinal};
        if (w.cmd == tkhs_pkg::CMD_OFFER) begin
            if (shadow_count < active_limit(shadow_limit)) begin
                shadow_hits[shadow_count] = hit;
                shadow_count++;
            end else begin
                // full: scan every held entry, replace the worst on a strict win
                worst = 0;
                for (int i = 1; i < shadow_count; i++)
                    if (ahead_of(shadow_hits[worst], shadow_hits[i])) worst = i;
                if (ahead_of(hit, shadow_hits[worst])) shadow_hits[worst] = hit;
            end
            r = '0;
            r.prune_threshold = min_kept_score();
            r.kept_count      = shadow_count[5:0];
            r.last_item       = 1'b1;
            pending_words.push_back(r);
        end else begin
            n = shadow_count;
            shadow_count = 0;
            if (n == 0) begin
                r = '0;
                r.last_item = 1'b1;
                pending_words.push_back(r);
            end
            // selection sort, emitting the best remaining hit each pass
            for (int i = 0; i < n; i++) begin
                best = i;
                for (int j = i + 1; j < n; j++)
                    if (ahead_of(shadow_hits[j], shadow_hits[best])) best = j;
                tmp               = shadow_hits[i];
                shadow_hits[i]    = shadow_hits[best];
                shadow_hits[best] = tmp;
                r = '0;
                r.out_valid   = 1'b1;
                r.out_score   = shadow_hits[i].score;
                r.out_kind    = shadow_hits[i].kind;
                r.out_ordinal = shadow_hits[i].ordinal;
                r.last_item   = (i == n - 1);
                pending_words.push_back(r);
            end
        end
    endtask

    // ---------------------------------------------------------------------
    // output side: stall pattern and checker
    // ---------------------------------------------------------------------

    always @(posedge i_clk) begin
        if (rx_hold_tgl != rx_hold_seen) begin
            // start the long hold-off; the block must fill and stall its input
            rx_hold_seen <= rx_hold_tgl;
            rx_hold_left <= HOLD_CYCLES;
            i_out_stall  <= 1'b1;
        end else if (rx_hold_left != 0) begin
            rx_hold_left <= rx_hold_left - 1;
            i_out_stall  <= 1'b1;
        end else if (o_out_valid && !i_out_stall) begin
            // word taken at this edge: draw the wait before the next one
            rx_draw      = quiet ? 0 : $urandom_range(0, 8);
            rx_wait_left <= rx_draw;
            i_out_stall  <= (rx_draw != 0);
        end else if (rx_wait_left > 1) begin
            rx_wait_left <= rx_wait_left - 1;
            i_out_stall  <= 1'b1;
        end else begin
            rx_wait_left <= 0;
            i_out_stall  <= 1'b0;
        end
    end

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_words.size() == 0) begin
                $display("%0t: word expected none actual %h", $time, o_out_data);
                mismatches++;
            end else begin
                want_w = pending_words.pop_front();
                compare_field("out_valid", 32'(want_w.out_valid),
                              32'(o_out_data.out_valid));
                compare_field("out_score", want_w.out_score, o_out_data.out_score);
                compare_field("out_kind", 32'(want_w.out_kind), 32'(o_out_data.out_kind));
                compare_field("out_ordinal", want_w.out_ordinal, o_out_data.out_ordinal);
                compare_field("prune_threshold", want_w.prune_threshold,
                              o_out_data.prune_threshold);
                compare_field("kept_count", 32'(want_w.kept_count),
                              32'(o_out_data.kept_count));
                compare_field("last_item", 32'(want_w.last_item),
                              32'(o_out_data.last_item));
            end
        end
    end

    // ---------------------------------------------------------------------
    // input side
    // ---------------------------------------------------------------------

    function automatic tkhs_pkg::t_hit_in make_hit(input logic cmd, input logic [31:0] score,
                                                   input logic [1:0] kind,
                                                   input logic [31:0] ord);
        tkhs_pkg::t_hit_in w;
        w.cmd         = cmd;
        w.hit_score   = score;
        w.hit_kind    = kind;
        w.hit_ordinal = ord;
        return w;
    endfunction

    // tie_mode 0: spread scores; 1: few scores and ordinals so ties decide;
    // 2: mostly the score extremes
    function automatic tkhs_pkg::t_hit_in random_hit(input int tie_mode, input logic cmd);
        logic [31:0] score;
        logic [31:0] ord;
        logic [1:0]  kind;
        case (tie_mode)
            1: begin
                score = $urandom_range(0, 3) << 16;
                ord   = $urandom_range(0, 3);
            end
            2: begin
                score = ($urandom_range(0, 1) == 0) ? 32'h0 : 32'hFFFF_FFFF;
                if ($urandom_range(0, 3) == 0) score = $urandom;
                ord   = ($urandom_range(0, 1) == 0) ? 32'h0 : 32'hFFFF_FFFF;
            end
            default: begin
                score = $urandom;
                ord   = $urandom;
            end
        endcase
        // kinds outside document/passage now and then
        kind = ($urandom_range(0, 7) == 0) ? 2'($urandom_range(0, 1) * 3)
                                            : 2'($urandom_range(1, 2));
        return make_hit(cmd, score, kind, ord);
    endfunction

    // offer one word after a random gap; valid stays up for a back-to-back word
    task automatic send_word(input tkhs_pkg::t_hit_in w);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 8);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= w;
        do @(posedge i_clk); while (o_in_stall);
        apply_to_shadow_list(w);
    endtask

    // drop valid, let every predicted word come out, then let the block settle
    task automatic wait_idle(input int extra);
        i_in_valid <= 1'b0;
        while (pending_words.size() != 0) @(posedge i_clk);
        repeat (extra) @(posedge i_clk);
    endtask

    task automatic write_keep_limit(input logic [5:0] v);
        wait_idle(SETTLE);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        shadow_limit = v;
    endtask

    // ---------------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------------

    // empty drain, two appends under the reset limit of 20, then a drain
    task automatic test_reset_state();
        send_word(make_hit(tkhs_pkg::CMD_DRAIN, 32'h0, 2'd0, 32'h0));
        send_word(make_hit(tkhs_pkg::CMD_OFFER, 32'h0003_8000, 2'd1, 32'd10));
        send_word(make_hit(tkhs_pkg::CMD_OFFER, 32'h0003_8000, 2'd2, 32'd9));
        send_word(make_hit(tkhs_pkg::CMD_DRAIN, 32'hFFFF_FFFF, 2'd3, 32'hFFFF_FFFF));
    endtask

    // field extremes, every tie-break and the strict replacement rule
    task automatic test_extremes();
        write_keep_limit(6'd4);
        send_word(make_hit(tkhs_pkg::CMD_OFFER, 32'hFFFF_FFFF, 2'd1, 32'h0));
        send_word(make_hit(tkhs_pkg::CMD_OFFER, 32'h0, 2'd2, 32'hFFFF_FFFF));
        send_word(make_hit(tkhs_pkg::CMD_OFFER, 32'h0001_0000, 2'd0, 32'd5));
        send_word(make_hit(tkhs_pkg::CMD_OFFER, 32'h0001_0000, 2'd3, 32'd5));
        // full now: a higher score pushes out the zero-score hit
        send_word(make_hit(tkhs_pkg::CMD_OFFER, 32'h0001_0000, 2'd1, 32'd7));
        // equal score, lower kind beats kind 3
        send_word(make_hit(tkhs_pkg::CMD_OFFER, 32'h0001_0000, 2'd0, 32'd4));
        // identical to the worst: no strict win, keep the list
        send_word(make_hit(tkhs_pkg::CMD_OFFER, 32'h0001_0000, 2'd1, 32'd7));
        // equal score and kind, lower ordinal wins
        send_word(make_hit(tkhs_pkg::CMD_OFFER, 32'h0001_0000, 2'd1, 32'd6));
        send_word(make_hit(tkhs_pkg::CMD_OFFER, 32'h0, 2'd0, 32'h0));
        send_word(make_hit(tkhs_pkg::CMD_DRAIN, 32'h0, 2'd0, 32'h0));
    endtask

    // a limit of zero behaves as one
    task automatic test_zero_limit();
        write_keep_limit(6'd0);
        send_word(make_hit(tkhs_pkg::CMD_OFFER, 32'h0000_0100, 2'd2, 32'd1));
        send_word(make_hit(tkhs_pkg::CMD_OFFER, 32'h0000_0200, 2'd2, 32'd2));
        send_word(make_hit(tkhs_pkg::CMD_OFFER, 32'h0000_0080, 2'd1, 32'd3));
        send_word(make_hit(tkhs_pkg::CMD_DRAIN, 32'h0, 2'd0, 32'h0));
    endtask

    // lower the limit under the held count: still full, entries kept
    task automatic test_limit_lowered();
        write_keep_limit(6'd8);
        for (int i = 0; i < 5; i++)
            send_word(make_hit(tkhs_pkg::CMD_OFFER, 32'h0002_0000 + 32'(i) * 32'h100,
                               2'd1, 32'(i)));
        write_keep_limit(6'd2);
        send_word(make_hit(tkhs_pkg::CMD_OFFER, 32'h0002_0280, 2'd2, 32'd40));
        send_word(make_hit(tkhs_pkg::CMD_OFFER, 32'h0001_0000, 2'd1, 32'd41));
        send_word(make_hit(tkhs_pkg::CMD_DRAIN, 32'h0, 2'd0, 32'h0));
    endtask

    // sets of offers with random content, each under a fresh limit
    task automatic test_random_sets();
        int         sent;
        int         n;
        int         tie_mode;
        logic [5:0] lim;
        sent = 0;
        while (sent < 160) begin
            case ($urandom_range(0, 9))
                0:       lim = 6'd0;
                1:       lim = 6'd1;
                2:       lim = 6'd32;
                3:       lim = 6'd63;
                4:       lim = 6'($urandom_range(33, 62));
                default: lim = 6'($urandom_range(2, 12));
            endcase
            write_keep_limit(lim);
            quiet    = ($urandom_range(0, 3) == 0);
            tie_mode = $urandom_range(0, 2);
            n        = $urandom_range(1, active_limit(lim) + 6);
            for (int i = 0; i < n; i++) begin
                // an odd stray drain in the middle of a set
                send_word(random_hit(tie_mode,
                                     ($urandom_range(0, 15) == 0) ? tkhs_pkg::CMD_DRAIN
                                                                  : tkhs_pkg::CMD_OFFER));
            end
            sent += n;
            // leave some sets undrained so the next limit meets a held list
            if ($urandom_range(0, 4) != 0) begin
                send_word(random_hit(0, tkhs_pkg::CMD_DRAIN));
                sent++;
            end
        end
        quiet = 1'b0;
    endtask

    // hold the output for a long stretch while offers keep coming
    task automatic test_backpressure();
        write_keep_limit(6'd6);
        quiet = 1'b1;
        @(posedge i_clk);
        rx_hold_tgl <= ~rx_hold_tgl;
        for (int i = 0; i < 12; i++) send_word(random_hit(1, tkhs_pkg::CMD_OFFER));
        quiet = 1'b0;
        send_word(random_hit(0, tkhs_pkg::CMD_DRAIN));
    endtask

    initial begin
        // hold the synchronous reset, then release it
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_state();
        test_extremes();
        test_zero_limit();
        test_limit_lowered();
        test_random_sets();
        test_backpressure();

        wait_idle(END_WAIT);
        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
